### design/rsst_pkg.sv
// Package for the sequence-number status tracker: operation codes, entry
// status codes, shared types and widths. No dependencies.
package rsst_pkg;

  localparam int unsigned WINDOW_DEF = 64;
  localparam int unsigned MAX_OUT    = 64;
  localparam int unsigned QDEPTH     = 2;

  typedef enum logic [2:0] {
    OP_HEARTBEAT  = 3'd0,
    OP_GAP        = 3'd1,
    OP_RECEIVED   = 3'd2,
    OP_IRRELEVANT = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_MISSING    = 3'd5,
    OP_MAX        = 3'd6,
    OP_MIN        = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_MISSING  = 2'd1,
    ST_RECEIVED = 2'd2,
    ST_LOST     = 2'd3
  } ent_t;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_FAIL     = 2'd1,
    RS_OVERFLOW = 2'd2
  } rstat_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] seq;
  } cmd_t;

  // Push request from the top level into the front-end queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qpush_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EXT,
    BK_FIRST,
    BK_SCAN,
    BK_POINT_RD,
    BK_POINT,
    BK_TRIM_HEAD,
    BK_TRIM_TAIL,
    BK_EMIT
  } bstate_t;

endpackage

### design/rsst_front.sv
// Front end: accepts commands into a short queue and hands them to the back.
// Depends on rsst_pkg.
module rsst_front
  import rsst_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  qpush_t push,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output cmd_t   head_cmd
);

  cmd_t       q_r [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;

  assign full       = (cnt_r == 2'(QDEPTH));
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push.valid) - 2'(pop);
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  // hold payloads
  always_ff @(posedge clk) begin
    if (push.valid) q_r[wp_r] <= push.cmd;
  end

endmodule

### design/rsst_back.sv
// Back end: window memory and sequencer that carries out one command at a
// time, one entry per cycle when scanning or appending. Depends on rsst_pkg.
module rsst_back
  import rsst_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_seq,
  output logic        out_last
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned OW = $clog2(MAX_OUT + 1);

  // memory entry: erased, relevant, status
  logic [3:0] mem [WINDOW];
  logic [3:0] rd_r;

  bstate_t     st_r, st_nxt;
  cmd_t        c_r;
  logic [63:0] head_r, lrm_r, tail_w, q_r, res_r, q_lst_r;
  logic [CW-1:0] cnt_r, i_r, fill_r;
  logic [OW-1:0] nout_r;
  logic        frp_r, have_r, flag_r;
  logic [1:0]  rst_r;
  logic        pend_r;
  logic        idle;

  logic        we;
  logic [AW-1:0] wa, ra;
  logic [3:0]  wd;

  assign tail_w = head_r + 64'(cnt_r) - 64'd1;
  assign idle   = (st_r == BK_IDLE);
  assign cmd_pop = idle && cmd_valid;

  // overflow check and span extension for the accepted command
  logic [63:0] need;
  logic        ext_ok, ext_any;
  always_comb begin
    need = '0; ext_ok = 1'b1; ext_any = 1'b0;
    if (cnt_r == '0) begin
      if (cmd.seq > lrm_r) begin
        need = cmd.seq - lrm_r; ext_any = 1'b1;
        ext_ok = (need <= 64'(WINDOW));
      end
    end else if (cmd.seq > tail_w) begin
      need = cmd.seq - tail_w; ext_any = 1'b1;
      ext_ok = (need <= 64'(WINDOW) - 64'(cnt_r));
    end
  end

  logic [3:0]  e;
  logic        e_er, e_done;
  logic [1:0]  e_st;
  assign e      = rd_r;
  assign e_er   = e[3];
  assign e_st   = e[1:0];
  assign e_done = (e_st == ST_RECEIVED) || (e_st == ST_LOST);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  // sequencer
  always_comb begin
    st_nxt = st_r; we = 1'b0; wa = '0; wd = '0;
    ra = AW'(head_r + 64'(i_r));
    unique case (st_r)
      BK_EXT: begin
        we = 1'b1; wa = AW'(q_r + 64'(fill_r)); wd = {1'b0, 1'b1, ST_UNKNOWN};
      end
      BK_FIRST: begin
        we = 1'b1; wa = AW'(c_r.seq); wd = {1'b0, 1'b1, ST_RECEIVED};
      end
      BK_POINT_RD: ra = AW'(c_r.seq);
      BK_TRIM_HEAD: ra = AW'(head_r);
      BK_TRIM_TAIL: ra = AW'(tail_w);
      default: ;
    endcase
    if (st_r == BK_SCAN && pend_r && !e_er) begin
      wa = AW'(q_lst_r); wd = e;
      unique case (c_r.op)
        OP_HEARTBEAT: if (e_st == ST_UNKNOWN && q_lst_r <= c_r.seq) begin
          we = 1'b1; wd[1:0] = ST_MISSING;
        end
        OP_GAP: if ((e_st == ST_UNKNOWN || e_st == ST_MISSING) && q_lst_r < c_r.seq)
        begin
          we = 1'b1; wd[1:0] = ST_LOST;
        end
        OP_REMOVE: if (!flag_r && q_lst_r <= c_r.seq && e_done) begin
          we = 1'b1; wd[3] = 1'b1;
        end
        default: ;
      endcase
    end
    if (st_r == BK_POINT) begin
      wa = AW'(c_r.seq); wd = e;
      wd[1:0] = ST_RECEIVED;
      if (c_r.op == OP_IRRELEVANT) wd[2] = 1'b0;
      we = (c_r.seq >= head_r) && (c_r.seq - head_r < 64'(cnt_r)) && !e_er;
    end
  end

  logic o_v, o_l; logic [1:0] o_s; logic [63:0] o_q;
  logic o_v_nxt, o_l_nxt; logic [1:0] o_s_nxt; logic [63:0] o_q_nxt;

  // result next values: held missing numbers during the scan, final result at the end
  always_comb begin
    o_v_nxt = 1'b0; o_s_nxt = rst_r; o_q_nxt = 64'd0; o_l_nxt = 1'b1;
    if (st_r == BK_SCAN && pend_r && !e_er && !flag_r && c_r.op == OP_MISSING &&
        e_st == ST_MISSING && e[2] && nout_r < OW'(MAX_OUT) && have_r) begin
      o_v_nxt = 1'b1; o_s_nxt = RS_OK; o_q_nxt = res_r; o_l_nxt = 1'b0;
    end
    if (st_r == BK_EMIT) begin
      if (c_r.op == OP_MISSING && rst_r == RS_OK) begin
        o_v_nxt = have_r; o_q_nxt = res_r;
      end else begin
        o_v_nxt = 1'b1;
        o_q_nxt = (c_r.op == OP_MAX) ? ((res_r < lrm_r) ? lrm_r : res_r) :
                  (c_r.op == OP_MIN) ? res_r : 64'd0;
      end
    end
  end

  // register the result ports
  always_ff @(posedge clk) begin
    if (!rst_n) o_v <= 1'b0;
    else o_v <= o_v_nxt;
    o_s <= o_s_nxt;
    o_q <= o_q_nxt;
    o_l <= o_l_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; head_r <= '0; cnt_r <= '0; lrm_r <= '0; frp_r <= 1'b1;
      pend_r <= 1'b0;
    end else begin
      unique case (st_r)
        BK_IDLE: if (cmd_valid) begin
          c_r <= cmd; i_r <= '0; nout_r <= '0; have_r <= 1'b0; flag_r <= 1'b0;
          res_r <= '0; pend_r <= 1'b0; fill_r <= CW'(1);
          if (cmd.op == OP_RECEIVED && frp_r && cnt_r == '0) begin
            head_r <= cmd.seq; cnt_r <= CW'(1); frp_r <= 1'b0;
            rst_r <= RS_OK; st_r <= BK_FIRST;
          end else if (cmd.op == OP_HEARTBEAT || cmd.op == OP_GAP ||
                       cmd.op == OP_RECEIVED || cmd.op == OP_IRRELEVANT) begin
            if (!ext_ok) begin
              rst_r <= RS_OVERFLOW; st_r <= BK_EMIT;
            end else begin
              rst_r <= RS_OK;
              if (cmd.op == OP_RECEIVED) frp_r <= 1'b0;
              if (ext_any) begin
                q_r <= (cnt_r == '0) ? lrm_r : tail_w;
                if (cnt_r == '0) head_r <= lrm_r + 64'd1;
                st_r <= BK_EXT;
              end else begin
                st_r <= (cmd.op == OP_HEARTBEAT || cmd.op == OP_GAP) ?
                        BK_SCAN : BK_POINT_RD;
              end
            end
          end else begin
            rst_r <= (cmd.op == OP_REMOVE || cmd.op == OP_MIN ||
                      (cmd.op == OP_MISSING && cnt_r == '0)) ? RS_FAIL : RS_OK;
            st_r <= (cmd.op == OP_MISSING && cnt_r == '0) ? BK_EMIT : BK_SCAN;
          end
        end
        BK_EXT: begin
          cnt_r <= cnt_r + CW'(1);
          fill_r <= fill_r + CW'(1);
          if (q_r + 64'(fill_r) == c_r.seq)
            st_r <= (c_r.op == OP_HEARTBEAT || c_r.op == OP_GAP) ?
                    BK_SCAN : BK_POINT_RD;
        end
        BK_FIRST: st_r <= BK_EMIT;
        BK_POINT_RD: st_r <= BK_POINT;
        BK_POINT: begin
          if (!((c_r.seq >= head_r) && (c_r.seq - head_r < 64'(cnt_r)) && !e_er))
            rst_r <= RS_FAIL;
          st_r <= BK_EMIT;
        end
        BK_SCAN: begin
          // one entry per cycle; pend_r marks rd_r valid for q_lst_r
          if (pend_r && !e_er && !flag_r) begin
            unique case (c_r.op)
              OP_REMOVE: begin
                if (q_lst_r > c_r.seq) flag_r <= 1'b1;
                else begin
                  if (e_done) lrm_r <= q_lst_r;
                  if (q_lst_r == c_r.seq) begin
                    rst_r <= e_done ? RS_OK : RS_FAIL; flag_r <= 1'b1;
                  end
                end
              end
              OP_MISSING: if (e_st == ST_MISSING && e[2] && nout_r < OW'(MAX_OUT)) begin
                res_r <= q_lst_r; have_r <= 1'b1; nout_r <= nout_r + OW'(1);
              end
              OP_MAX: if (e_done) res_r <= q_lst_r; else flag_r <= 1'b1;
              OP_MIN: begin
                if (e_st == ST_RECEIVED) begin
                  rst_r <= RS_OK; res_r <= q_lst_r; flag_r <= 1'b1;
                end else if (e_st != ST_LOST) flag_r <= 1'b1;
              end
              default: ;
            endcase
          end
          q_lst_r <= head_r + 64'(i_r);
          if (i_r < cnt_r) begin
            pend_r <= 1'b1; i_r <= i_r + CW'(1);
          end else if (pend_r) begin
            pend_r <= 1'b0;
          end else begin
            st_r <= (c_r.op == OP_REMOVE) ? BK_TRIM_HEAD : BK_EMIT;
          end
        end
        BK_TRIM_HEAD: begin
          // drop erased entries at the oldest end; read, then check
          if (cnt_r == '0) st_r <= BK_EMIT;
          else if (!pend_r) pend_r <= 1'b1;
          else begin
            pend_r <= 1'b0;
            if (e_er) begin
              head_r <= head_r + 64'd1; cnt_r <= cnt_r - CW'(1);
            end else st_r <= BK_TRIM_TAIL;
          end
        end
        BK_TRIM_TAIL: begin
          // drop erased entries at the newest end; read, then check
          if (cnt_r == '0) st_r <= BK_EMIT;
          else if (!pend_r) pend_r <= 1'b1;
          else begin
            pend_r <= 1'b0;
            if (e_er) cnt_r <= cnt_r - CW'(1);
            else st_r <= BK_EMIT;
          end
        end
        BK_EMIT: st_r <= BK_IDLE;
        default: st_r <= BK_IDLE;
      endcase
    end
  end

  assign out_valid  = o_v;
  assign out_status = o_s;
  assign out_seq    = o_q;
  assign out_last   = o_l;

endmodule

### design/reliable_seqnum_status_tracker_top.sv
// Sequence-number status tracker, top level.
// A scan reads every entry of the span; an update first appends unknown entries up to
// its number, and remove-up-to then trims erased entries from both ends. The very first
// receive, an overflow and an empty missing list skip the window walk.
// Throughput: one command per scan; a two-entry queue takes commands ahead.
// Reset: synchronous active-low rst_n clears control state; window memory
// holds undefined contents until written. Results cannot be stalled.
module reliable_seqnum_status_tracker_top
  import rsst_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_seq,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [63:0] out_result_seq,
  output logic        out_last
);

  qpush_t push;
  logic   full, pop, hv;
  cmd_t   hc;

  assign busy = full;
  assign push = '{valid: start && !full, cmd: '{op: op_t'(in_mode), seq: in_seq}};

  rsst_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .pop(pop), .head_valid(hv), .head_cmd(hc)
  );

  rsst_back #(.WINDOW(WINDOW)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(hv), .cmd(hc), .cmd_pop(pop),
    .out_valid(out_strobe), .out_status(out_status),
    .out_seq(out_result_seq), .out_last(out_last)
  );

endmodule

### design/rsst_checker.sv
// Port checker for the tracker top level, with its bind statement.
// Depends on rsst_pkg and the top level's ports.
module rsst_checker
  import rsst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [63:0] out_result_seq,
  input logic        out_last
);

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status <= RS_OVERFLOW) else $error("bad status code");
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == RS_OVERFLOW |-> out_last) else $error("overflow not last");
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == RS_OVERFLOW |-> out_result_seq == 64'd0)
    else $error("overflow with value");
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !start && !busy |=> !busy) else $error("busy without a new item");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("activity after reset");

endmodule

bind reliable_seqnum_status_tracker_top rsst_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_status(out_status), .out_result_seq(out_result_seq), .out_last(out_last)
);

### tb/sv/tb_reliable_seqnum_status_tracker_checker.sv
// Checker for the sequence-number status tracker: watches accepted items and
// results, predicts each result from its own window model and compares.
// Depends on rsst_pkg.
`timescale 1ns / 100ps

module tb_reliable_seqnum_status_tracker_checker
  import rsst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_seq,
  input  logic        out_strobe,
  input  logic [1:0]  out_status,
  input  logic [63:0] out_result_seq,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);

  localparam int unsigned WIN = WINDOW_DEF;

  typedef struct packed {
    rstat_t      status;
    logic [63:0] seq;
    logic        last;
  } tracker_result_t;

  // Window model
  ent_t        ent_status [WIN];
  logic        ent_relevant [WIN];
  logic        ent_erased [WIN];
  logic [63:0] head_seq;
  int unsigned live_span;
  logic [63:0] removed_seq;
  logic        first_rx_pending;

  tracker_result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic int unsigned slot_of(logic [63:0] s);
    return int'(s % WIN);
  endfunction

  // Append unknown entries up to s; return 0 on overflow with nothing changed
  function automatic bit grow_window(logic [63:0] s);
    logic [63:0] tail;
    logic [63:0] need;
    int unsigned p;
    if (live_span == 0) begin
      if (s <= removed_seq) return 1;
      need = s - removed_seq;
      if (need > WIN) return 0;
      head_seq = removed_seq + 1;
      tail = removed_seq;
    end else begin
      tail = head_seq + live_span - 1;
      if (s <= tail) return 1;
      need = s - tail;
      if (need > WIN - live_span) return 0;
    end
    for (logic [63:0] i = 1; i <= need; i++) begin
      p = slot_of(tail + i);
      ent_status[p] = ST_UNKNOWN;
      ent_relevant[p] = 1'b1;
      ent_erased[p] = 1'b0;
    end
    live_span += int'(need);
    return 1;
  endfunction

  function automatic bit is_live(logic [63:0] s);
    if (live_span == 0 || s < head_seq) return 0;
    if (s - head_seq >= live_span) return 0;
    return !ent_erased[slot_of(s)];
  endfunction

  function automatic void push_result(rstat_t st, logic [63:0] v, logic l);
    tracker_result_t r;
    r.status = st;
    r.seq = v;
    r.last = l;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Predict the results of one accepted item
  function automatic void predict_item(op_t op, logic [63:0] s);
    rstat_t      st;
    logic [63:0] r;
    logic [63:0] q;
    int unsigned p;
    int          n;
    bit          done;
    st = RS_OK;
    r = '0;
    case (op)
      OP_HEARTBEAT, OP_GAP: begin
        if (!grow_window(s)) st = RS_OVERFLOW;
        else begin
          for (int unsigned i = 0; i < live_span; i++) begin
            q = head_seq + i;
            p = slot_of(q);
            if (ent_erased[p]) continue;
            if (op == OP_HEARTBEAT) begin
              if (ent_status[p] == ST_UNKNOWN && q <= s) ent_status[p] = ST_MISSING;
            end else if ((ent_status[p] == ST_UNKNOWN || ent_status[p] == ST_MISSING)
                         && q < s) begin
              ent_status[p] = ST_LOST;
            end
          end
        end
      end
      OP_RECEIVED, OP_IRRELEVANT: begin
        if (op == OP_RECEIVED && first_rx_pending && live_span == 0) begin
          p = slot_of(s);
          head_seq = s;
          live_span = 1;
          ent_status[p] = ST_RECEIVED;
          ent_relevant[p] = 1'b1;
          ent_erased[p] = 1'b0;
          first_rx_pending = 1'b0;
        end else if (!grow_window(s)) begin
          st = RS_OVERFLOW;
        end else begin
          if (op == OP_RECEIVED) first_rx_pending = 1'b0;
          if (!is_live(s)) st = RS_FAIL;
          else begin
            ent_status[slot_of(s)] = ST_RECEIVED;
            if (op == OP_IRRELEVANT) ent_relevant[slot_of(s)] = 1'b0;
          end
        end
      end
      OP_REMOVE: begin
        st = RS_FAIL;
        for (int unsigned i = 0; i < live_span; i++) begin
          q = head_seq + i;
          p = slot_of(q);
          if (ent_erased[p]) continue;
          if (q > s) break;
          done = ent_status[p] == ST_RECEIVED || ent_status[p] == ST_LOST;
          if (done) begin
            ent_erased[p] = 1'b1;
            removed_seq = q;
          end
          if (q == s) begin
            st = done ? RS_OK : RS_FAIL;
            break;
          end
        end
        // drop erased entries at both ends of the span
        while (live_span > 0 && ent_erased[slot_of(head_seq)]) begin
          head_seq++;
          live_span--;
        end
        while (live_span > 0 && ent_erased[slot_of(head_seq + live_span - 1)])
          live_span--;
      end
      OP_MISSING: begin
        if (live_span == 0) begin
          push_result(RS_FAIL, '0, 1'b1);
        end else begin
          n = 0;
          for (int unsigned i = 0; i < live_span && n < MAX_OUT; i++) begin
            q = head_seq + i;
            p = slot_of(q);
            if (!ent_erased[p] && ent_status[p] == ST_MISSING && ent_relevant[p]) begin
              push_result(RS_OK, q, 1'b0);
              n++;
            end
          end
          if (n > 0) expected_results[$].last = 1'b1;
        end
        return;
      end
      OP_MAX: begin
        for (int unsigned i = 0; i < live_span; i++) begin
          q = head_seq + i;
          p = slot_of(q);
          if (ent_erased[p]) continue;
          if (ent_status[p] == ST_RECEIVED || ent_status[p] == ST_LOST) r = q;
          else break;
        end
        if (r < removed_seq) r = removed_seq;
      end
      default: begin
        st = RS_FAIL;
        for (int unsigned i = 0; i < live_span; i++) begin
          q = head_seq + i;
          p = slot_of(q);
          if (ent_erased[p]) continue;
          if (ent_status[p] == ST_RECEIVED) begin
            st = RS_OK;
            r = q;
            break;
          end
          if (ent_status[p] != ST_LOST) break;
        end
      end
    endcase
    push_result(st, r, 1'b1);
  endfunction

  // Watch both channels
  always @(posedge clk) begin
    tracker_result_t exp_r;
    if (!rst_n) begin
      head_seq = '0;
      live_span = 0;
      removed_seq = '0;
      first_rx_pending = 1'b1;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d seq=%0d last=%0d",
                   $time, out_status, out_result_seq, out_last);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_status !== exp_r.status || out_result_seq !== exp_r.seq ||
              out_last !== exp_r.last) begin
            $display("%0t: mismatch expected status=%0d seq=%0d last=%0d,",
                     $time, exp_r.status, exp_r.seq, exp_r.last,
                     " actual status=%0d seq=%0d last=%0d",
                     out_status, out_result_seq, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_item(op_t'(in_mode), in_seq);
    end
  end

endmodule

### tb/sv/tb_reliable_seqnum_status_tracker_top.sv
// Testbench top for the sequence-number status tracker: drives directed and
// random items and gives the verdict. Depends on rsst_pkg and the checker.
`timescale 1ns / 100ps

module tb_reliable_seqnum_status_tracker_top
  import rsst_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [63:0] in_seq = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [63:0] out_result_seq;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  logic [63:0] seq_base = '0;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reliable_seqnum_status_tracker_top i_dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_seq,
    .out_strobe, .out_status, .out_result_seq, .out_last
  );

  tb_reliable_seqnum_status_tracker_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_mode, .in_seq,
    .out_strobe, .out_status, .out_result_seq, .out_last,
    .fail_count, .pending_count
  );

  // Hold an item until accepted, then idle a random gap
  task automatic send_item(op_t op, logic [63:0] s);
    int gap;
    start <= 1'b1;
    in_mode <= op;
    in_seq <= s;
    do @(posedge clk); while (busy);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      in_mode <= 3'($urandom);
      in_seq <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Seq near the base, mostly inside the window
  function automatic logic [63:0] near_seq();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return {$urandom, $urandom};
    if (sel == 1) return seq_base + $urandom_range(64, 90);
    if (sel == 2 && seq_base > 5) return seq_base - $urandom_range(1, 5);
    return seq_base + $urandom_range(0, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    op_t op;
    logic [63:0] s;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: queries on an empty window, first receive, extremes
    send_item(OP_MISSING, '0);
    send_item(OP_MAX, '0);
    send_item(OP_MIN, '0);
    send_item(OP_REMOVE, 64'd5);
    send_item(OP_HEARTBEAT, 64'd100);
    send_item(OP_IRRELEVANT, 64'd3);
    send_item(OP_RECEIVED, 64'd10);
    send_item(OP_RECEIVED, 64'd10);
    send_item(OP_HEARTBEAT, 64'd64);
    send_item(OP_MISSING, '0);
    send_item(OP_RECEIVED, 64'd12);
    send_item(OP_IRRELEVANT, 64'd13);
    send_item(OP_GAP, 64'd20);
    send_item(OP_MIN, '0);
    send_item(OP_MAX, '0);
    send_item(OP_REMOVE, 64'd15);
    send_item(OP_REMOVE, 64'd25);
    send_item(OP_RECEIVED, 64'd2);
    send_item(OP_MISSING, '0);
    send_item(OP_GAP, 64'd74);
    send_item(OP_REMOVE, 64'd73);
    send_item(OP_MAX, '0);
    send_item(OP_HEARTBEAT, 64'hFFFF_FFFF_FFFF_FFFF);

    // Hold off until the directed results have drained
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    seq_base = 64'd74;

    // Random: mostly well-formed traffic near the window, some noise
    for (int k = 0; k < 75; k++) begin
      op = op_t'($urandom_range(0, 7));
      s = near_seq();
      send_item(op, s);
      if (op == OP_REMOVE && s > seq_base && s - seq_base < 64) seq_base = s;
    end
    // High seq bits: jump the whole flow far up once the window is cleared
    send_item(OP_GAP, seq_base + 41);
    send_item(OP_REMOVE, seq_base + 41);
    send_item(OP_HEARTBEAT, 64'hFFFF_FFFF_FFFF_FFC0);
    send_item(OP_RECEIVED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_MISSING, '0);

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### reliable_seqnum_status_tracker_top.f
design/rsst_pkg.sv
design/rsst_front.sv
design/rsst_back.sv
design/reliable_seqnum_status_tracker_top.sv
design/rsst_checker.sv
tb/sv/tb_reliable_seqnum_status_tracker_checker.sv
tb/sv/tb_reliable_seqnum_status_tracker_top.sv
